// ----- rtl/bcb_pkg.sv -----
// bcb_pkg: beat types and fixed widths for the block change bitmap
// no dependencies
package bcb_pkg;

    localparam int unsigned SHIFT_W         = 5;
    localparam int unsigned FLAGS_PER_BYTE  = 8;
    localparam int unsigned HELD_W          = 3;
    localparam logic [SHIFT_W-1:0] RESET_BLOCK_SHIFT = 5'd12;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       second_present;
        logic       region_end;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] bitmap_byte;
        logic       last_of_region;
    } t_out_beat;

    // block close report from the tracker to the packer
    typedef struct packed {
        logic close;
        logic dirty;
        logic region_end;
    } t_close_info;

endpackage

// ----- rtl/bcb_block_track.sv -----
// bcb_block_track: block size register, byte offset counter and dirty flag
// depends on bcb_pkg
module bcb_block_track #(
    parameter int unsigned MAX_BLOCK_SHIFT = 30
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bcb_pkg::SHIFT_W-1:0] i_cfg_data,
    input  bcb_pkg::t_in_beat           i_beat,
    input  logic                        i_advance,
    output bcb_pkg::t_close_info        o_close
);

    localparam int unsigned OFS_W = (MAX_BLOCK_SHIFT > 0) ? MAX_BLOCK_SHIFT : 1;
    localparam logic [bcb_pkg::SHIFT_W-1:0] SHIFT_MAX = bcb_pkg::SHIFT_W'(MAX_BLOCK_SHIFT);

    logic [bcb_pkg::SHIFT_W-1:0] r_block_shift;
    logic [OFS_W-1:0]            r_offset, n_offset;
    logic                        r_dirty, n_dirty;
    logic [bcb_pkg::SHIFT_W-1:0] shift_eff;
    logic [OFS_W-1:0]            last_offset;
    logic                        dirty;
    logic                        close;

    always_comb begin
        shift_eff   = (r_block_shift > SHIFT_MAX) ? SHIFT_MAX : r_block_shift;
        last_offset = ~({OFS_W{1'b1}} << shift_eff);
        dirty       = r_dirty | ~i_beat.second_present
                      | (i_beat.first_byte != i_beat.second_byte);
        close       = (r_offset == last_offset) | i_beat.region_end;
        if (close) begin
            n_offset = '0;
            n_dirty  = 1'b0;
        end else begin
            n_offset = r_offset + OFS_W'(1);
            n_dirty  = dirty;
        end
        o_close.close      = close;
        o_close.dirty      = dirty;
        o_close.region_end = i_beat.region_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_shift <= bcb_pkg::RESET_BLOCK_SHIFT;
            r_offset      <= '0;
            r_dirty       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_block_shift <= i_cfg_data;
            end
            if (i_advance) begin
                r_offset <= n_offset;
                r_dirty  <= n_dirty;
            end
        end
    end

endmodule

// ----- rtl/bcb_flag_pack.sv -----
// bcb_flag_pack: flag accumulator, byte emission and output register
// depends on bcb_pkg
module bcb_flag_pack (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  bcb_pkg::t_close_info i_close,
    input  logic                 i_out_stall,
    output logic                 o_advance,
    output logic                 o_out_valid,
    output bcb_pkg::t_out_beat   o_out_data
);

    logic [7:0]                  r_acc, n_acc;
    logic [bcb_pkg::HELD_W-1:0]  r_held, n_held;
    logic                        r_out_valid;
    bcb_pkg::t_out_beat          r_out_data, n_out_data;
    logic [7:0]                  acc_shift;
    logic                        produce;
    logic                        out_free;

    always_comb begin
        acc_shift = {r_acc[6:0], i_close.dirty};
        produce   = i_close.close
                    & (i_close.region_end | (r_held == bcb_pkg::HELD_W'(7)));
        out_free  = ~r_out_valid | ~i_out_stall;
        o_advance = i_item_valid & (~produce | out_free);

        n_out_data.last_of_region = i_close.region_end;
        // pad the tail byte: shift up by the number of unused flags
        n_out_data.bitmap_byte    = i_close.region_end ? (acc_shift << (~r_held)) : acc_shift;

        n_acc  = r_acc;
        n_held = r_held;
        if (i_close.close) begin
            if (produce) begin
                n_acc  = '0;
                n_held = '0;
            end else begin
                n_acc  = acc_shift;
                n_held = r_held + bcb_pkg::HELD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_acc  <= n_acc;
                r_held <= n_held;
            end
            if (o_advance && produce) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && produce) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/block_change_bitmap.sv -----
// block_change_bitmap: top level, input register and the two working stages
// depends on bcb_pkg, bcb_block_track, bcb_flag_pack
//
//   channel   direction  handshake            payload
//   in        sink       i_in_valid/o_in_stall  t_in_beat
//   out       source     o_out_valid/i_out_stall t_out_beat
//   cfg       sink       i_cfg_valid/o_cfg_ready block_shift, 5 bits
//
// one byte pair per cycle; a pair is registered, then the offset counter,
// dirty flag and flag accumulator update when the pair advances
// each bitmap byte is held in the output register until it is taken
// an input beat is held back only when it closes a byte and the output
// register is full and stalled
// synchronous active low reset clears all counters, flags and valids
module block_change_bitmap #(
    parameter int unsigned MAX_BLOCK_SHIFT = 30
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bcb_pkg::SHIFT_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  bcb_pkg::t_in_beat           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output bcb_pkg::t_out_beat          o_out_data
);

    logic                 r_in_valid;
    bcb_pkg::t_in_beat    r_in_data;
    logic                 advance;
    logic                 in_take;
    bcb_pkg::t_close_info close_info;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_in_valid & ~advance;
    assign in_take     = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in_data;
        end
    end

    bcb_block_track #(
        .MAX_BLOCK_SHIFT(MAX_BLOCK_SHIFT)
    ) u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid & o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_beat     (r_in_data),
        .i_advance  (advance),
        .o_close    (close_info)
    );

    bcb_flag_pack u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_in_valid),
        .i_close      (close_info),
        .i_out_stall  (i_out_stall),
        .o_advance    (advance),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

endmodule

// ----- rtl/bcb_checker.sv -----
// bcb_checker: port level checks for block_change_bitmap, bound to the top
// depends on bcb_pkg, block_change_bitmap
module bcb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_cfg_ready,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input bcb_pkg::t_out_beat          o_out_data
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // input only backs up when the output is full and stalled
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back pressure");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("valid or stall left set by reset");

endmodule

bind block_change_bitmap bcb_checker u_bcb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_cfg_ready (o_cfg_ready),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ----- verif/block_change_bitmap_test.sv -----
`timescale 1ns / 1ps
// block_change_bitmap_test: self-checking bench for the block change bitmap
// streams byte pairs through the block and checks every bitmap beat in order
// depends on bcb_pkg and block_change_bitmap
module block_change_bitmap_test;

    localparam int MAX_SHIFT    = 30;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 10;
    localparam int RANDOM_PAIRS = 1950;
    localparam int REPORT_LIMIT = 10;
    localparam logic [bcb_pkg::SHIFT_W-1:0] SHIFT_OVERSIZED = 5'd31;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [bcb_pkg::SHIFT_W-1:0] i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_stall;
    bcb_pkg::t_in_beat           i_in_data;
    logic                        o_out_valid;
    logic                        i_out_stall;
    bcb_pkg::t_out_beat          o_out_data;

    // predictor state
    logic [bcb_pkg::SHIFT_W-1:0] pred_shift;
    logic [29:0]                 pred_offset;
    logic                        pred_dirty;
    logic [7:0]                  pred_flags;
    logic [bcb_pkg::HELD_W-1:0]  pred_held;

    bcb_pkg::t_out_beat bitmap_expect[$];
    int        errors = 0;
    int        idle_pct = 0;
    int        pairs_sent = 0;
    int        rx_wait = 0;
    logic      rx_stall = 1'b0;
    logic      rx_long_hold = 1'b0;
    event      hold_start;

    assign i_out_stall = rx_stall | rx_long_hold;

    block_change_bitmap #(
        .MAX_BLOCK_SHIFT(MAX_SHIFT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int pick_gap();
        if ($urandom_range(99) >= idle_pct) begin
            return 0;
        end
        if ($urandom_range(9) == 0) begin
            return $urandom_range(40, 10);
        end
        return $urandom_range(3, 1);
    endfunction

    function automatic bcb_pkg::t_in_beat make_pair(input logic [7:0] a, input logic [7:0] b,
                                                    input logic present, input logic end_flag);
        bcb_pkg::t_in_beat p;
        p.first_byte     = a;
        p.second_byte    = b;
        p.second_present = present;
        p.region_end     = end_flag;
        return p;
    endfunction

    function automatic bcb_pkg::t_in_beat random_pair(input int diff_pct, input logic end_flag);
        bcb_pkg::t_in_beat p;
        p.first_byte     = 8'($urandom);
        p.second_byte    = p.first_byte;
        p.second_present = 1'b1;
        p.region_end     = end_flag;
        if ($urandom_range(99) < diff_pct) begin
            if ($urandom_range(3) == 0) begin
                p.second_present = 1'b0;
                p.second_byte    = 8'($urandom);
            end else begin
                p.second_byte = p.first_byte ^ 8'($urandom_range(255, 1));
            end
        end
        return p;
    endfunction

    // block tracker and flag packer, one accepted pair at a time
    task automatic predict_bitmap(input bcb_pkg::t_in_beat p);
        int                 eff_shift;
        logic [29:0]        last_offset;
        logic               dirty_now;
        int                 held_now;
        bcb_pkg::t_out_beat beat;
        eff_shift   = (pred_shift > MAX_SHIFT) ? MAX_SHIFT : int'(pred_shift);
        last_offset = 30'((31'd1 << eff_shift) - 31'd1);
        dirty_now   = pred_dirty | (p.second_present ?
                                    (p.first_byte != p.second_byte) : 1'b1);
        if (pred_offset != last_offset && !p.region_end) begin
            pred_offset = pred_offset + 30'd1;
            pred_dirty  = dirty_now;
        end else begin
            pred_offset = '0;
            pred_dirty  = 1'b0;
            pred_flags  = {pred_flags[6:0], dirty_now};
            held_now    = int'(pred_held) + 1;
            if (p.region_end) begin
                if (held_now < bcb_pkg::FLAGS_PER_BYTE) begin
                    pred_flags = pred_flags << (bcb_pkg::FLAGS_PER_BYTE - held_now);
                end
                beat.bitmap_byte    = pred_flags;
                beat.last_of_region = 1'b1;
                bitmap_expect.push_back(beat);
                pred_flags = '0;
                pred_held  = '0;
            end else if (held_now >= bcb_pkg::FLAGS_PER_BYTE) begin
                beat.bitmap_byte    = pred_flags;
                beat.last_of_region = 1'b0;
                bitmap_expect.push_back(beat);
                pred_flags = '0;
                pred_held  = '0;
            end else begin
                pred_held = bcb_pkg::HELD_W'(held_now);
            end
        end
    endtask

    task automatic check_bitmap_beat(input bcb_pkg::t_out_beat got);
        bcb_pkg::t_out_beat want;
        if (bitmap_expect.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
                $display("unexpected bitmap beat: byte %02h last %0b",
                         got.bitmap_byte, got.last_of_region);
            end
        end else begin
            want = bitmap_expect.pop_front();
            if (got.bitmap_byte !== want.bitmap_byte ||
                got.last_of_region !== want.last_of_region) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("bitmap mismatch: expected %02h last %0b, got %02h last %0b",
                             want.bitmap_byte, want.last_of_region,
                             got.bitmap_byte, got.last_of_region);
                end
            end
        end
    endtask

    // output side: check accepted beats and stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_bitmap_beat(o_out_data);
        end
        if (rx_wait > 0) begin
            rx_stall <= 1'b1;
            rx_wait = rx_wait - 1;
        end else begin
            rx_stall <= 1'b0;
            rx_wait = pick_gap();
        end
    end

    // long receiver hold-off
    initial begin
        forever begin
            @(hold_start);
            rx_long_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_long_hold <= 1'b0;
        end
    end

    task automatic send_pair(input bcb_pkg::t_in_beat p);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        do @(posedge i_clk); while (o_in_stall);
        predict_bitmap(p);
        pairs_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (bitmap_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_block_shift(input logic [bcb_pkg::SHIFT_W-1:0] shift);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= shift;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pred_shift = shift;
    endtask

    task automatic run_region(input int len, input int diff_pct, input logic close);
        for (int i = 0; i < len; i++) begin
            send_pair(random_pair(diff_pct, close && (i == len - 1)));
        end
    endtask

    // reset block size, short regions, byte extremes
    task automatic test_reset_shift();
        idle_pct = 30;
        send_pair(make_pair(8'hFF, 8'hFF, 1'b1, 1'b0));
        send_pair(make_pair(8'h00, 8'h00, 1'b1, 1'b0));
        send_pair(make_pair(8'h5A, 8'h5A, 1'b1, 1'b1));
        send_pair(make_pair(8'h00, 8'hFF, 1'b1, 1'b0));
        send_pair(make_pair(8'hFF, 8'hFF, 1'b1, 1'b1));
    endtask

    // one-byte blocks: full byte, region end on the eighth flag, missing bytes, padding
    task automatic test_single_byte_blocks();
        set_block_shift(5'd0);
        for (int i = 0; i < 8; i++) begin
            send_pair(make_pair(8'hA5, (i % 2 == 0) ? 8'h5A : 8'hA5, 1'b1, 1'b0));
        end
        for (int i = 0; i < 8; i++) begin
            send_pair(make_pair(8'h3C, 8'h3C, 1'b0, i == 7));
        end
        send_pair(make_pair(8'h81, 8'h81, 1'b1, 1'b0));
        send_pair(make_pair(8'h7E, 8'h7E, 1'b0, 1'b0));
        send_pair(make_pair(8'hC3, 8'hC3, 1'b1, 1'b1));
    endtask

    // largest and clamped block sizes
    task automatic test_oversized_shift();
        set_block_shift(SHIFT_OVERSIZED);
        send_pair(make_pair(8'h11, 8'h11, 1'b1, 1'b0));
        send_pair(make_pair(8'h22, 8'h22, 1'b1, 1'b1));
        set_block_shift(5'(MAX_SHIFT));
        send_pair(make_pair(8'h01, 8'h80, 1'b1, 1'b1));
    endtask

    task automatic test_random_streams();
        logic [bcb_pkg::SHIFT_W-1:0] shift;
        int pick;
        int regions;
        int len;
        int diff_pct;
        while (pairs_sent < RANDOM_PAIRS) begin
            pick = $urandom_range(19);
            if (pick < 12) begin
                shift = 5'($urandom_range(3));
            end else if (pick < 16) begin
                shift = 5'($urandom_range(6, 4));
            end else if (pick == 16) begin
                shift = bcb_pkg::RESET_BLOCK_SHIFT;
            end else if (pick < 19) begin
                shift = 5'(MAX_SHIFT);
            end else begin
                shift = SHIFT_OVERSIZED;
            end
            set_block_shift(shift);
            idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 10);
            regions  = $urandom_range(6, 1);
            for (int r = 0; r < regions; r++) begin
                len = (shift > 6) ? $urandom_range(20, 1) : $urandom_range(96, 1);
                case ($urandom_range(4))
                    0: diff_pct = 0;
                    1: diff_pct = 3;
                    2: diff_pct = 15;
                    3: diff_pct = 50;
                    default: diff_pct = 100;
                endcase
                run_region(len, diff_pct, (r == regions - 1) || ($urandom_range(4) != 0));
            end
        end
    endtask

    // receiver holds off while the sender keeps offering, then the sender waits it out
    task automatic test_backpressure();
        set_block_shift(5'd0);
        idle_pct = 0;
        -> hold_start;
        run_region(200, 50, 1'b1);
        drain_results();
        idle_pct = 30;
        run_region(40, 50, 1'b1);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        pred_shift  = bcb_pkg::RESET_BLOCK_SHIFT;
        pred_offset = '0;
        pred_dirty  = 1'b0;
        pred_flags  = '0;
        pred_held   = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_shift();
        test_single_byte_blocks();
        test_oversized_shift();
        test_backpressure();
        test_random_streams();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (bitmap_expect.size() != 0) begin
            errors++;
        end
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bcb_pkg.sv
rtl/bcb_block_track.sv
rtl/bcb_flag_pack.sv
rtl/block_change_bitmap.sv
rtl/bcb_checker.sv
verif/block_change_bitmap_test.sv
